/* rtl/core/rld_pkg.sv */
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types, character codes and helpers of the run-length decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rld_pkg;

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;

    // widths
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 4;

    // controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } rld_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // take the input word
        logic push;       // write one result word to the output register
        logic push_last;  // that result is the last one of its input word
    } rld_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic in_has_results;  // the input word causes at least one result
        logic slot_free;       // output register free or being drained
        logic count_zero;      // no copies left
        logic count_one;       // one copy left
        logic emit_self;       // the held byte is emitted once after its copies
    } rld_stat_t;

    // letter or space
    function automatic logic is_emit_char(input logic [BYTE_W-1:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ))
            || (c == CH_SPACE);
    endfunction

    // decimal digit
    function automatic logic is_digit_char(input logic [BYTE_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/rld_ctrl.sv */
// ----------------------------------------------------------------------------
// rld_ctrl
// Controller: accepts one input word, then steps the datapath through the
// result words that word causes.
// ----------------------------------------------------------------------------
`default_nettype none

module rld_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire rld_pkg::rld_stat_t stat,
    output rld_pkg::rld_cmd_t       cmd
);
    import rld_pkg::*;

    rld_state_t state_reg;
    rld_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.push      = 1'b0;
        cmd.push_last = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (stat.in_has_results)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (stat.slot_free)
                begin
                    cmd.push      = 1'b1;
                    cmd.push_last = stat.count_zero || (stat.count_one && !stat.emit_self);
                    if (cmd.push_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/rld_dp.sv */
// ----------------------------------------------------------------------------
// rld_dp
// Datapath: held byte, copy counter, pending repeat and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rld_dp
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [rld_pkg::BYTE_W-1:0] s_tdata,
    input  wire logic                       s_tlast,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [rld_pkg::BYTE_W-1:0]      m_tdata,
    output logic                            m_tlast,
    input  wire rld_pkg::rld_cmd_t          cmd,
    output rld_pkg::rld_stat_t              stat
);
    import rld_pkg::*;

    logic [BYTE_W-1:0]  byte_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] pend_reg;
    logic [COUNT_W-1:0] pend_next;
    logic               self_reg;
    logic               valid_reg;
    logic               valid_next;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               out_last_reg;
    logic [BYTE_W-1:0]  digit_val;

    // repeat set by a digit: d-1 copies, none for zero
    assign digit_val = s_tdata - CH_ZERO;

    always_comb
    begin
        pend_next  = pend_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            count_next = pend_reg;
            pend_next  = '0;
            if (is_digit_char(s_tdata) && !s_tlast && (digit_val != '0))
            begin
                pend_next = COUNT_W'(digit_val - 1'b1);
            end
        end
        else if (cmd.push && (count_reg != '0))
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // output register valid
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.push)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg  <= pend_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= s_tdata;
            self_reg <= is_emit_char(s_tdata);
        end
        if (cmd.push)
        begin
            out_byte_reg <= byte_reg;
            out_last_reg <= cmd.push_last;
        end
    end

    // status to controller
    always_comb
    begin
        stat.in_has_results = (pend_reg != '0) || is_emit_char(s_tdata);
        stat.slot_free      = !valid_reg || m_tready;
        stat.count_zero     = (count_reg == '0);
        stat.count_one      = (count_reg == COUNT_W'(1));
        stat.emit_self      = self_reg;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* rtl/core/run_length_decoder.sv */
// ----------------------------------------------------------------------------
// run_length_decoder
// Expands run-length coded bytes, one result word per cycle when not stalled.
// ----------------------------------------------------------------------------
// A digit d in the input stores a repeat of d-1 copies (none for '0') owed to
// the next byte; that byte is first output that many times, then output once
// more if it is a letter or space, or sets a new repeat if it is a digit;
// other bytes are dropped. s_tlast on a byte clears the repeat after it.
// m_tlast marks the last result word caused by one input word. An input word
// is taken in the idle state, and its results then leave at one word per cycle
// through the output register while m_tready allows; input is held off while the
// copy counter runs.
`default_nettype none

module run_length_decoder
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [rld_pkg::BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    input  wire logic                       s_tlast,   // in_last
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [rld_pkg::BYTE_W-1:0]      m_tdata,   // [7:0] out_byte
    output logic                            m_tlast    // run_last
);
    import rld_pkg::*;

    rld_cmd_t  cmd;
    rld_stat_t stat;

    // sequencer
    rld_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // byte, counter and output register
    rld_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire

/* rtl/core/rld_checker.sv */
// ----------------------------------------------------------------------------
// rld_port_checker
// Port-level checks of the run-length decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rld_port_checker
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic [rld_pkg::BYTE_W-1:0] s_tdata,
    input wire logic                       s_tlast,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [rld_pkg::BYTE_W-1:0] m_tdata,
    input wire logic                       m_tlast
);
    import rld_pkg::*;

    // a stalled output word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    // a stalled output word keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    // no new input while a run is still being emitted
    a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken in the middle of a run");

    // a letter or space always causes results, so input closes next cycle
    a_letter_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && is_emit_char(s_tdata) |=> !s_tready)
        else $error("letter accepted without emitting");

    // a valid output word carries a known payload
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !$isunknown({m_tdata, m_tlast}))
        else $error("output payload unknown while valid");

endmodule

bind run_length_decoder rld_port_checker u_rld_checker (.*);

`default_nettype wire
